@@ sv/busdec_pkg.sv @@
// Shared types, codes and address map constants of the bus address decoder.
package busdec_pkg;

   localparam int DEVICE_SLOTS_DEFAULT = 384;

   typedef enum logic [2:0] {
      MODE_READ_BYTE  = 3'd0,
      MODE_READ_WORD  = 3'd1,
      MODE_WRITE_BYTE = 3'd2,
      MODE_WRITE_WORD = 3'd3,
      MODE_PEEK_BYTE  = 3'd4,
      MODE_SET_SLOT   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      TARGET_RAM     = 3'd0,
      TARGET_IPL     = 3'd1,
      TARGET_CG      = 3'd2,
      TARGET_SCSI    = 3'd3,
      TARGET_DEVICE  = 3'd4,
      TARGET_FIXED   = 3'd5,
      TARGET_IGNORED = 3'd6,
      TARGET_NONE    = 3'd7
   } target_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BUS_ERROR  = 2'd1,
      STATUS_ADDR_ERROR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ROM_SASI          = 3'd0,
      ROM_SCSI_INTERNAL = 3'd1,
      ROM_SCSI_EXTERNAL = 3'd2,
      ROM_XVI           = 3'd3,
      ROM_COMPACT       = 3'd4,
      ROM_030           = 3'd5
   } rom_kind_type;

   localparam logic [1:0] CSR_ROM_TYPE = 2'd0;
   localparam logic [1:0] CSR_RAM_SIZE = 2'd1;

   localparam logic [2:0] RAM_CODE_MAX = 3'd5;

   localparam logic [23:0] DEV_BASE      = 24'hC00000;
   localparam logic [23:0] CG_BASE       = 24'hF00000;
   localparam logic [23:0] SCSI_AREA     = 24'hFC0000;
   localparam logic [23:0] SCSI_ROM_END  = 24'hFC2000;
   localparam logic [23:0] IPL_BASE      = 24'hFE0000;
   localparam logic [23:0] EXT_SCSI_LO   = 24'hEA0020;
   localparam logic [23:0] EXT_SCSI_HI   = 24'hEA1FFF;
   localparam logic [23:0] IPL_MASK      = 24'h01FFFF;
   localparam logic [23:0] SCSI_MASK     = 24'h001FFF;
   localparam logic [23:0] CG_MASK       = 24'h0FFFFF;
   localparam logic [23:0] SHADOW_SIZE   = 24'h010000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [23:0] address;
      logic [15:0] write_data;
      logic        reset_fetch;
      logic [8:0]  slot_index;
      logic        slot_present;
   } req_type;

   typedef struct packed {
      logic [2:0]  target;
      logic [23:0] offset;
      logic [8:0]  device_slot;
      logic [15:0] data_value;
      logic [1:0]  status;
   } rsp_type;

endpackage

@@ sv/busdec_ram.sv @@
// Generic synchronous RAM, one write port and one registered read port.
module busdec_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bus_address_decoder_unit.sv @@
// Top level of the bus address decoder: map lookup, decode and output register.
//
// Decodes one 24-bit bus access per clock into target store, byte-swapped
// offset, device slot, data value and status. An item passes the lookup
// stage, which reads the device-present bit from the slot map RAM through its
// registered read port, and then the decode stage, which decodes into the
// output register; items follow each other every cycle while the result side
// keeps up and no map clearing runs. Set-slot items write the map at their
// accept edge, so later items always see the update. After reset the map RAM
// is cleared one slot per cycle over all DEVICE_SLOTS slots (384 by default),
// and req_stall stays high meanwhile; CSR writes are taken at any time.
module bus_address_decoder_unit #(
   parameter int DEVICE_SLOTS = busdec_pkg::DEVICE_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  busdec_pkg::req_type req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output busdec_pkg::rsp_type rsp_item,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [2:0]          csr_data
);
   import busdec_pkg::*;

   localparam int SLOT_AW = DEVICE_SLOTS > 1 ? $clog2(DEVICE_SLOTS) : 1;
   localparam logic [9:0] SLOT_LIMIT = 10'(DEVICE_SLOTS);
   localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(DEVICE_SLOTS - 1);

   logic [2:0]         rom_type_ff, ram_size_ff;
   logic               clear_busy_ff;
   logic [SLOT_AW-1:0] clear_ff;
   logic               s1_valid_ff, s1_valid_in;
   req_type            s1_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, res;

   logic               out_free, s1_move, accept;
   logic               map_wr_en, map_rd_data;
   logic [SLOT_AW-1:0] map_wr_addr;
   logic               map_wr_data;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_type_ff <= ROM_SASI;
         ram_size_ff <= 3'd0;
      end else if (csr_write) begin
         if (csr_index == CSR_ROM_TYPE) begin
            rom_type_ff <= csr_data;
         end else if (csr_index == CSR_RAM_SIZE) begin
            ram_size_ff <= csr_data;
         end
      end
   end

   // map clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_ff      <= '0;
      end else if (clear_busy_ff) begin
         clear_ff <= clear_ff + 1'b1;
         if (clear_ff == LAST_SLOT) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign s1_move      = s1_valid_ff && out_free;
   assign req_stall    = clear_busy_ff || (s1_valid_ff && !out_free);
   assign accept       = req_valid && !req_stall;
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && rsp_stall);

   always_comb begin
      map_wr_en   = 1'b0;
      map_wr_addr = req_item.slot_index[SLOT_AW-1:0];
      map_wr_data = req_item.slot_present;
      if (clear_busy_ff) begin
         map_wr_en   = 1'b1;
         map_wr_addr = clear_ff;
         map_wr_data = 1'b0;
      end else if (accept && req_item.mode == MODE_SET_SLOT &&
                   {1'b0, req_item.slot_index} < SLOT_LIMIT) begin
         map_wr_en = 1'b1;
      end
   end

   busdec_ram #(
      .WIDTH(1),
      .DEPTH(DEVICE_SLOTS)
   ) u_map (
      .clock  (clock),
      .wr_en  (map_wr_en),
      .wr_addr(map_wr_addr),
      .wr_data(map_wr_data),
      .rd_en  (accept),
      .rd_addr(req_item.address[13 +: SLOT_AW]),
      .rd_data(map_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_item;
      end
      if (s1_move) begin
         out_ff <= res;
      end
   end

   // decode
   logic [23:0] a, flipped, dev_offset;
   logic [15:0] fixed_val, wdata;
   logic [8:0]  slot;
   logic [2:0]  code_sat;
   logic        is_word, is_write, is_peek, in_ram, dev_range, hit, scsi_rom;

   always_comb begin
      a          = s1_ff.address;
      is_word    = s1_ff.mode == MODE_READ_WORD || s1_ff.mode == MODE_WRITE_WORD;
      is_write   = s1_ff.mode == MODE_WRITE_BYTE || s1_ff.mode == MODE_WRITE_WORD;
      is_peek    = s1_ff.mode == MODE_PEEK_BYTE;
      flipped    = a ^ {23'd0, !is_word};
      fixed_val  = is_word ? 16'hFFFF : 16'h00FF;
      wdata      = is_word ? s1_ff.write_data : {8'd0, s1_ff.write_data[7:0]};
      code_sat   = ram_size_ff > RAM_CODE_MAX ? RAM_CODE_MAX : ram_size_ff;
      in_ram     = a[23:21] <= code_sat;
      dev_range  = a >= DEV_BASE && a < CG_BASE;
      slot       = a[21:13];
      dev_offset = {2'b00, a[21:0]};
      hit        = dev_range && ({1'b0, slot} < SLOT_LIMIT) && map_rd_data;
      scsi_rom   = rom_type_ff != ROM_SASI && rom_type_ff != ROM_SCSI_EXTERNAL;

      res = '{target: TARGET_NONE, offset: '0, device_slot: '0,
              data_value: '0, status: STATUS_OK};

      case (s1_ff.mode)
         MODE_READ_BYTE, MODE_READ_WORD, MODE_WRITE_BYTE, MODE_WRITE_WORD,
         MODE_PEEK_BYTE: begin
            if (is_word && a[0]) begin
               res.data_value = is_write ? wdata : fixed_val;
               res.status     = STATUS_ADDR_ERROR;
            end else if (is_write) begin
               res.data_value = wdata;
               if (in_ram) begin
                  res.target = TARGET_RAM;
                  res.offset = flipped;
               end else if (a >= CG_BASE) begin
                  res.target = TARGET_IGNORED;
               end else if (hit) begin
                  res.target      = TARGET_DEVICE;
                  res.offset      = dev_offset;
                  res.device_slot = slot;
               end else begin
                  res.status = STATUS_BUS_ERROR;
               end
            end else if (a < SHADOW_SIZE && s1_ff.reset_fetch) begin
               res.target = TARGET_IPL;
               res.offset = (a + SHADOW_SIZE) ^ {23'd0, !is_word};
            end else if (in_ram) begin
               res.target = TARGET_RAM;
               res.offset = flipped;
            end else if (a >= IPL_BASE) begin
               res.target = TARGET_IPL;
               res.offset = flipped & IPL_MASK;
            end else if (a >= SCSI_AREA) begin
               if (!scsi_rom) begin
                  res.target = TARGET_IPL;
                  res.offset = flipped & IPL_MASK;
               end else if (a < SCSI_ROM_END) begin
                  res.target = TARGET_SCSI;
                  res.offset = flipped & SCSI_MASK;
               end else if (rom_type_ff == ROM_030) begin
                  res.target = TARGET_SCSI;
                  res.offset = flipped & IPL_MASK;
               end else begin
                  res.target     = TARGET_FIXED;
                  res.data_value = fixed_val;
               end
            end else if (a >= CG_BASE) begin
               res.target = TARGET_CG;
               res.offset = flipped & CG_MASK;
            end else if (rom_type_ff == ROM_SCSI_EXTERNAL &&
                         a >= EXT_SCSI_LO && a <= EXT_SCSI_HI) begin
               res.target = TARGET_SCSI;
               res.offset = flipped & SCSI_MASK;
            end else if (hit) begin
               res.target      = TARGET_DEVICE;
               res.offset      = dev_offset;
               res.device_slot = slot;
            end else if (is_peek) begin
               res.target     = TARGET_FIXED;
               res.data_value = 16'h00FF;
            end else begin
               res.data_value = fixed_val;
               res.status     = STATUS_BUS_ERROR;
            end
         end
         default: begin
            res.target = TARGET_NONE;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !rsp_valid)
      else $error("result shown during map clearing");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("stalled item lost in lookup stage");

   a_addr_err_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STATUS_ADDR_ERROR) |->
      (rsp_item.target == TARGET_NONE))
      else $error("address error with a target");

   a_device_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.target == TARGET_DEVICE) |->
      ({1'b0, rsp_item.device_slot} < SLOT_LIMIT &&
       rsp_item.offset[21:13] == rsp_item.device_slot))
      else $error("device result with bad slot");

endmodule
